// File: hw/rtl/dds_pkg.sv
// ----------------------------------------------------------------------------
// dds_pkg: shared types and constants
// Pipeline load strobes, register map and settings for the drive step block.
// ----------------------------------------------------------------------------
package dds_pkg;

  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 3;
  localparam int GAIN_W      = 12;
  localparam int DRIVE_W     = 8;
  localparam int LIMIT_W     = 7;
  localparam int SETTLE_W    = 8;
  localparam int AVG_W       = 24;
  localparam int STALL_W     = 5;
  localparam int GAIN_FRAC   = 8;
  localparam int WIDE_W      = 40;  // holds any intermediate magnitude for compares

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TARGET_LEFT  = 3'd0,
    REG_TARGET_RIGHT = 3'd1,
    REG_DRIVE_LIMIT  = 3'd2,
    REG_GAIN_STRAIGHT = 3'd3,
    REG_GAIN_TURNING = 3'd4,
    REG_ACCEL_STRAIGHT = 3'd5,
    REG_ACCEL_TURNING = 3'd6,
    REG_SETTLE_ERROR = 3'd7
  } reg_index_t;

  // one load strobe per pipeline stage
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
  } pipe_ctl_t;

  // settings shared by both wheels
  typedef struct packed {
    logic [LIMIT_W-1:0]  drive_limit;
    logic [GAIN_W-1:0]   gain_straight;
    logic [GAIN_W-1:0]   gain_turning;
    logic [LIMIT_W-1:0]  accel_straight;
    logic [LIMIT_W-1:0]  accel_turning;
    logic [SETTLE_W-1:0] settle_error;
  } drive_cfg_t;

endpackage

// File: hw/rtl/dds_if.sv
// ----------------------------------------------------------------------------
// dds_if: request channels
// Valid/ready channels for encoder positions in and drive commands out.
// ----------------------------------------------------------------------------
interface dds_in_if #(parameter int POSITION_BITS = 24);
  logic                            valid;
  logic                            ready;
  logic signed [POSITION_BITS-1:0] left_position;
  logic signed [POSITION_BITS-1:0] right_position;
  logic                            new_move;

  modport source (output valid, left_position, right_position, new_move, input ready);
  modport sink (input valid, left_position, right_position, new_move, output ready);
endinterface

interface dds_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] left_drive;
  logic signed [7:0] right_drive;
  logic              finished;
  logic [23:0]       average_error;

  modport source (output valid, left_drive, right_drive, finished, average_error, input ready);
  modport sink (input valid, left_drive, right_drive, finished, average_error, output ready);
endinterface

// File: hw/rtl/differential_drive_slew_p_step_top.sv
// ----------------------------------------------------------------------------
// differential_drive_slew_p_step_top: proportional drive step with slew limit
// Two wheel lanes form errors and gain products; a merge stage keeps the
// slew cap, stall count and exit state and registers the drive request.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  in_ch     in   valid/ready   left_position, right_position, new_move
//  out_ch    out  valid/ready   left_drive, right_drive, finished, average_error
//  cfg       in   cfg_write     cfg_index, cfg_data (write only)
//
//  One request per clock sustained while out_ch takes each result; out_ch.valid
//  rises when a request has passed four register stages (error, magnitude,
//  multiply, state/clamp); the error stage loads on the accepting edge itself.
//  The loop state (slew cap, last error, stall count, done) closes within the
//  last stage alone, so back-to-back requests need no bubbles.
//  Each stage holds when the one after it is full and stalled; in_ch.ready
//  drops only when every stage is full and out_ch is not taken.
//  rst is synchronous: clears the pipeline and loop state, loads register
//  defaults.
// ----------------------------------------------------------------------------
module differential_drive_slew_p_step_top
  import dds_pkg::*;
#(
  parameter int STALL_TICKS   = 20,
  parameter int POSITION_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  dds_in_if.sink                 in_ch,
  dds_out_if.source              out_ch,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // configuration registers
  logic signed [POSITION_BITS-1:0] target_left_ticks;
  logic signed [POSITION_BITS-1:0] target_right_ticks;
  drive_cfg_t                      cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_left_ticks  <= '0;
      target_right_ticks <= '0;
      cfg.drive_limit    <= LIMIT_W'(115);
      cfg.gain_straight  <= GAIN_W'(38);
      cfg.gain_turning   <= GAIN_W'(179);
      cfg.accel_straight <= LIMIT_W'(5);
      cfg.accel_turning  <= LIMIT_W'(4);
      cfg.settle_error   <= SETTLE_W'(5);
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        // 24-bit register data, resized to a POSITION_BITS-wide target
        REG_TARGET_LEFT:    target_left_ticks  <= POSITION_BITS'(cfg_data);
        REG_TARGET_RIGHT:   target_right_ticks <= POSITION_BITS'(cfg_data);
        REG_DRIVE_LIMIT:    cfg.drive_limit    <= cfg_data[LIMIT_W-1:0];
        REG_GAIN_STRAIGHT:  cfg.gain_straight  <= cfg_data[GAIN_W-1:0];
        REG_GAIN_TURNING:   cfg.gain_turning   <= cfg_data[GAIN_W-1:0];
        REG_ACCEL_STRAIGHT: cfg.accel_straight <= cfg_data[LIMIT_W-1:0];
        REG_ACCEL_TURNING:  cfg.accel_turning  <= cfg_data[LIMIT_W-1:0];
        REG_SETTLE_ERROR:   cfg.settle_error   <= cfg_data[SETTLE_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline occupancy; each stage advances when the next has room
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;
  pipe_ctl_t ctl;

  assign rdy4 = !v4 || out_ch.ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign ctl.ld1 = in_ch.valid && rdy1;
  assign ctl.ld2 = v1 && rdy2;
  assign ctl.ld3 = v2 && rdy3;
  assign ctl.ld4 = v3 && rdy4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= ctl.ld1 || (v1 && !ctl.ld2);
      v2 <= ctl.ld2 || (v2 && !ctl.ld3);
      v3 <= ctl.ld3 || (v3 && !ctl.ld4);
      v4 <= ctl.ld4 || (v4 && !out_ch.ready);
    end
  end

  assign in_ch.ready  = rdy1;
  assign out_ch.valid = v4;

  // lanes
  logic [GAIN_W-1:0]               gain;
  logic                            l_err_neg, l_err_nz, r_err_neg, r_err_nz;
  logic [POSITION_BITS:0]          l_mag, r_mag;
  logic [POSITION_BITS+GAIN_W:0]   l_prod, r_prod;
  logic                            l_prod_neg, r_prod_neg;

  dds_lane #(.POSITION_BITS(POSITION_BITS)) u_lane_left (
    .clk      (clk),
    .ctl      (ctl),
    .position (in_ch.left_position),
    .target   (target_left_ticks),
    .gain     (gain),
    .err_neg  (l_err_neg),
    .err_nz   (l_err_nz),
    .mag      (l_mag),
    .prod     (l_prod),
    .prod_neg (l_prod_neg)
  );

  dds_lane #(.POSITION_BITS(POSITION_BITS)) u_lane_right (
    .clk      (clk),
    .ctl      (ctl),
    .position (in_ch.right_position),
    .target   (target_right_ticks),
    .gain     (gain),
    .err_neg  (r_err_neg),
    .err_nz   (r_err_nz),
    .mag      (r_mag),
    .prod     (r_prod),
    .prod_neg (r_prod_neg)
  );

  dds_merge #(
    .POSITION_BITS (POSITION_BITS),
    .STALL_TICKS   (STALL_TICKS)
  ) u_merge (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .cfg           (cfg),
    .new_move      (in_ch.new_move),
    .l_err_neg     (l_err_neg),
    .l_err_nz      (l_err_nz),
    .r_err_neg     (r_err_neg),
    .r_err_nz      (r_err_nz),
    .l_mag         (l_mag),
    .r_mag         (r_mag),
    .l_prod        (l_prod),
    .r_prod        (r_prod),
    .l_prod_neg    (l_prod_neg),
    .r_prod_neg    (r_prod_neg),
    .gain          (gain),
    .left_drive    (out_ch.left_drive),
    .right_drive   (out_ch.right_drive),
    .finished      (out_ch.finished),
    .average_error (out_ch.average_error)
  );

  // a finished move drives nothing
  assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.finished) |-> (out_ch.left_drive == 0 && out_ch.right_drive == 0))
    else $error("drive nonzero on finished request");

  // drives never exceed the configured limit
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> ($signed(out_ch.left_drive) <= $signed({1'b0, cfg.drive_limit}) &&
                      $signed(out_ch.left_drive) >= -$signed({1'b0, cfg.drive_limit})))
    else $error("left drive beyond limit");

  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> ($signed(out_ch.right_drive) <= $signed({1'b0, cfg.drive_limit}) &&
                      $signed(out_ch.right_drive) >= -$signed({1'b0, cfg.drive_limit})))
    else $error("right drive beyond limit");

endmodule

// File: hw/rtl/dds_lane.sv
// ----------------------------------------------------------------------------
// dds_lane: one wheel's error path
// Error to target, magnitude and sign, then magnitude times the Q4.8 gain.
// ----------------------------------------------------------------------------
module dds_lane
  import dds_pkg::*;
#(
  parameter int POSITION_BITS = 24
) (
  input  logic                             clk,
  input  pipe_ctl_t                        ctl,
  input  logic signed [POSITION_BITS-1:0]  position,
  input  logic signed [POSITION_BITS-1:0]  target,
  input  logic [GAIN_W-1:0]                gain,
  output logic                             err_neg,
  output logic                             err_nz,
  output logic [POSITION_BITS:0]           mag,
  output logic [POSITION_BITS+GAIN_W:0]    prod,
  output logic                             prod_neg
);

  localparam int EW = POSITION_BITS + 1;
  localparam int PW = POSITION_BITS + GAIN_W + 1;

  logic signed [EW-1:0] err1;
  logic                 neg2;
  logic [EW-1:0]        mag2;

  // stage 1: signed error, one bit wider than the positions
  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      err1 <= EW'(target) - EW'(position);
    end
  end

  assign err_neg = err1[EW-1];
  assign err_nz  = |err1;

  // stage 2: magnitude and sign
  always_ff @(posedge clk) begin
    if (ctl.ld2) begin
      neg2 <= err1[EW-1];
      mag2 <= err1[EW-1] ? EW'(-err1) : EW'(err1);
    end
  end

  assign mag = mag2;

  // stage 3: gain product, shifted later
  always_ff @(posedge clk) begin
    if (ctl.ld3) begin
      prod     <= PW'(mag2) * PW'(gain);
      prod_neg <= neg2;
    end
  end

endmodule

// File: hw/rtl/dds_merge.sv
// ----------------------------------------------------------------------------
// dds_merge: combines both lanes
// Straight/turn choice, average error, slew cap, exit logic and result register.
// ----------------------------------------------------------------------------
module dds_merge
  import dds_pkg::*;
#(
  parameter int POSITION_BITS = 24,
  parameter int STALL_TICKS   = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pipe_ctl_t                     ctl,
  input  drive_cfg_t                    cfg,
  input  logic                          new_move,
  input  logic                          l_err_neg,
  input  logic                          l_err_nz,
  input  logic                          r_err_neg,
  input  logic                          r_err_nz,
  input  logic [POSITION_BITS:0]        l_mag,
  input  logic [POSITION_BITS:0]        r_mag,
  input  logic [POSITION_BITS+GAIN_W:0] l_prod,
  input  logic [POSITION_BITS+GAIN_W:0] r_prod,
  input  logic                          l_prod_neg,
  input  logic                          r_prod_neg,
  output logic [GAIN_W-1:0]             gain,
  output logic signed [DRIVE_W-1:0]     left_drive,
  output logic signed [DRIVE_W-1:0]     right_drive,
  output logic                          finished,
  output logic [AVG_W-1:0]              average_error
);

  localparam int SW = POSITION_BITS + 2;
  localparam int PW = POSITION_BITS + GAIN_W + 1;
  localparam logic [STALL_W-1:0] STALL_MAX = '1;
  localparam logic [STALL_W-1:0] STALL_LIM = STALL_W'(STALL_TICKS);

  logic nm1, nm2, nm3;
  logic straight2, straight3;
  logic [AVG_W-1:0] avg3;

  // loop state
  logic [LIMIT_W-1:0] slew_cap;
  logic [AVG_W-1:0]   previous_error;
  logic [STALL_W-1:0] stall_count;
  logic               done_flag;

  // zero is its own sign
  logic straight_now;
  assign straight_now = (l_err_nz == r_err_nz) && (!l_err_nz || (l_err_neg == r_err_neg));

  logic [SW-1:0]     mag_sum;
  logic [WIDE_W-1:0] half_w;
  logic [AVG_W-1:0]  avg_now;
  assign mag_sum = SW'(l_mag) + SW'(r_mag);
  assign half_w  = WIDE_W'(mag_sum[SW-1:1]);
  assign avg_now = (half_w > WIDE_W'({AVG_W{1'b1}})) ? {AVG_W{1'b1}} : half_w[AVG_W-1:0];

  assign gain = straight2 ? cfg.gain_straight : cfg.gain_turning;

  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      nm1 <= new_move;
    end
    if (ctl.ld2) begin
      nm2       <= nm1;
      straight2 <= straight_now;
    end
    if (ctl.ld3) begin
      nm3       <= nm2;
      straight3 <= straight2;
      avg3      <= avg_now;
    end
  end

  // stage 4: state update, seen with a new move clearing it first
  logic [LIMIT_W-1:0] eff_slew;
  logic [AVG_W-1:0]   eff_prev;
  logic [STALL_W-1:0] eff_stall;
  logic               eff_done;
  logic [LIMIT_W-1:0] accel;
  logic [LIMIT_W:0]   cap_sum;
  logic [LIMIT_W-1:0] cap;
  logic [STALL_W-1:0] stall_next;
  logic               exit_now;
  logic               done_next;
  logic [LIMIT_W-1:0] slew_next;
  logic [AVG_W-1:0]   prev_next;
  logic [LIMIT_W-1:0] l_mag_drv, r_mag_drv;
  logic [WIDE_W-1:0]  l_sh, r_sh;

  always_comb begin
    eff_slew  = nm3 ? '0 : slew_cap;
    eff_prev  = nm3 ? '0 : previous_error;
    eff_stall = nm3 ? '0 : stall_count;
    eff_done  = nm3 ? 1'b0 : done_flag;

    accel   = straight3 ? cfg.accel_straight : cfg.accel_turning;
    cap_sum = (LIMIT_W+1)'(eff_slew) + (LIMIT_W+1)'(accel);
    cap     = (cap_sum > (LIMIT_W+1)'(cfg.drive_limit)) ? cfg.drive_limit
                                                         : cap_sum[LIMIT_W-1:0];

    if (eff_prev == avg3) begin
      stall_next = (eff_stall < STALL_MAX) ? eff_stall + 1'b1 : eff_stall;
    end else begin
      stall_next = '0;
    end

    exit_now = ((eff_prev < AVG_W'(cfg.settle_error)) && (avg3 < AVG_W'(cfg.settle_error)))
               || (stall_next >= STALL_LIM);

    l_sh = WIDE_W'(l_prod[PW-1:GAIN_FRAC]);
    r_sh = WIDE_W'(r_prod[PW-1:GAIN_FRAC]);
    l_mag_drv = (l_sh > WIDE_W'(cap)) ? cap : l_sh[LIMIT_W-1:0];
    r_mag_drv = (r_sh > WIDE_W'(cap)) ? cap : r_sh[LIMIT_W-1:0];

    if (eff_done) begin
      done_next  = 1'b1;
      slew_next  = eff_slew;
      prev_next  = eff_prev;
      stall_next = eff_stall;
    end else begin
      done_next = exit_now;
      slew_next = cap;
      prev_next = exit_now ? eff_prev : avg3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slew_cap       <= '0;
      previous_error <= '0;
      stall_count    <= '0;
      done_flag      <= 1'b0;
    end else if (ctl.ld4) begin
      slew_cap       <= slew_next;
      previous_error <= prev_next;
      stall_count    <= stall_next;
      done_flag      <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld4) begin
      finished      <= done_next;
      average_error <= avg3;
      if (done_next) begin
        left_drive  <= '0;
        right_drive <= '0;
      end else begin
        left_drive  <= l_prod_neg ? -DRIVE_W'(l_mag_drv) : DRIVE_W'(l_mag_drv);
        right_drive <= r_prod_neg ? -DRIVE_W'(r_mag_drv) : DRIVE_W'(r_mag_drv);
      end
    end
  end

endmodule

// File: tb/tb_differential_drive_slew_p_step_top.sv
// ----------------------------------------------------------------------------
// tb_differential_drive_slew_p_step_top: self-checking bench for the drive step
// Drives encoder position requests with random gaps and output stalls, keeps a
// cycle-free model of the loop state, and checks every drive request in order.
// ----------------------------------------------------------------------------
module tb_differential_drive_slew_p_step_top;
  import dds_pkg::*;

  localparam int     STALL_TICKS   = 20;
  localparam int     POSITION_BITS = 24;
  localparam int     PIPE_LATENCY  = 3;        // acceptance to out_ch.valid
  localparam int     HOLD_CYCLES   = 40;       // long receiver hold-off
  localparam int     RANDOM_PHASES = 6;
  localparam int     PHASE_ITEMS   = 145;
  localparam int     MAX_REPORTS   = 10;
  localparam int     RUN_LIMIT     = 5_000_000;
  localparam longint POS_MAX       = (64'sd1 <<< (POSITION_BITS - 1)) - 1;
  localparam longint POS_MIN       = -(64'sd1 <<< (POSITION_BITS - 1));
  localparam longint AVG_TOP       = (64'sd1 <<< AVG_W) - 1;

  // one drive request as seen on out_ch
  typedef struct packed {
    logic signed [DRIVE_W-1:0] left_drive;
    logic signed [DRIVE_W-1:0] right_drive;
    logic                      finished;
    logic [AVG_W-1:0]          average_error;
  } drive_cmd_t;

  // --------------------------------------------------------------------------
  // Loop model: register copy, slew/stall/exit state and the drive requests
  // still owed by the block, oldest first.
  // --------------------------------------------------------------------------
  class slew_step_tracker;
    logic signed [POSITION_BITS-1:0] tgt_left;
    logic signed [POSITION_BITS-1:0] tgt_right;
    drive_cfg_t                      cfg;
    logic [LIMIT_W-1:0]              slew_cap;
    logic [AVG_W-1:0]                last_avg;
    logic [STALL_W-1:0]              flat_ticks;
    bit                              move_done;
    drive_cmd_t                      expected_drives[$];
    int                              mismatches;
    int                              checked;
    int                              settle_exits;
    int                              stall_exits;

    function new();
      tgt_left           = '0;
      tgt_right          = '0;
      cfg.drive_limit    = 115;
      cfg.gain_straight  = 38;
      cfg.gain_turning   = 179;
      cfg.accel_straight = 5;
      cfg.accel_turning  = 4;
      cfg.settle_error   = 5;
      slew_cap           = '0;
      last_avg           = '0;
      flat_ticks         = '0;
      move_done          = 1'b0;
    endfunction

    function void note_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_TARGET_LEFT:    tgt_left = data[POSITION_BITS-1:0];
        REG_TARGET_RIGHT:   tgt_right = data[POSITION_BITS-1:0];
        REG_DRIVE_LIMIT:    cfg.drive_limit = data[LIMIT_W-1:0];
        REG_GAIN_STRAIGHT:  cfg.gain_straight = data[GAIN_W-1:0];
        REG_GAIN_TURNING:   cfg.gain_turning = data[GAIN_W-1:0];
        REG_ACCEL_STRAIGHT: cfg.accel_straight = data[LIMIT_W-1:0];
        REG_ACCEL_TURNING:  cfg.accel_turning = data[LIMIT_W-1:0];
        REG_SETTLE_ERROR:   cfg.settle_error = data[SETTLE_W-1:0];
        default: ;
      endcase
    endfunction

    static function int sign3(longint v);
      if (v > 0) return 1;
      if (v < 0) return -1;
      return 0;
    endfunction

    // |err| * Q4.8 gain, truncated toward zero, clamped to +-lim
    static function longint limited_drive(longint err, longint gain, longint lim);
      longint m;
      m = ((err < 0 ? -err : err) * gain) >>> GAIN_FRAC;
      if (m > lim) m = lim;
      return (err < 0) ? -m : m;
    endfunction

    function void take_positions(logic signed [POSITION_BITS-1:0] lpos,
                                 logic signed [POSITION_BITS-1:0] rpos,
                                 logic nm);
      longint     el, er, avg, gain, accel, c, dl, dr;
      bit         straight;
      drive_cmd_t want;
      if (nm) begin
        slew_cap   = '0;
        last_avg   = '0;
        flat_ticks = '0;
        move_done  = 1'b0;
      end
      el  = longint'(tgt_left) - longint'(lpos);
      er  = longint'(tgt_right) - longint'(rpos);
      avg = ((el < 0 ? -el : el) + (er < 0 ? -er : er)) >>> 1;
      if (avg > AVG_TOP) avg = AVG_TOP;
      dl = 0;
      dr = 0;
      if (!move_done) begin
        // zero is its own sign: two zero errors still count as straight
        straight = sign3(el) == sign3(er);
        gain  = straight ? cfg.gain_straight : cfg.gain_turning;
        accel = straight ? cfg.accel_straight : cfg.accel_turning;
        c = longint'(slew_cap) + accel;
        if (c > cfg.drive_limit) c = cfg.drive_limit;
        slew_cap = LIMIT_W'(c);
        dl = limited_drive(el, gain, c);
        dr = limited_drive(er, gain, c);
        if (longint'(last_avg) == avg) begin
          if (flat_ticks != '1) flat_ticks++;
        end else begin
          flat_ticks = '0;
        end
        // exit tick keeps the old average as last error
        if (last_avg < cfg.settle_error && avg < cfg.settle_error) begin
          move_done = 1'b1;
          settle_exits++;
        end else if (flat_ticks >= STALL_TICKS) begin
          move_done = 1'b1;
          stall_exits++;
        end else begin
          last_avg = AVG_W'(avg);
        end
      end
      if (move_done) begin
        dl = 0;
        dr = 0;
      end
      want.left_drive    = DRIVE_W'(dl);
      want.right_drive   = DRIVE_W'(dr);
      want.finished      = move_done;
      want.average_error = AVG_W'(avg);
      expected_drives.push_back(want);
    endfunction

    function void compare_drive(drive_cmd_t got);
      drive_cmd_t want;
      if (expected_drives.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: unexpected drive L=%0d R=%0d fin=%0b avg=%0d",
                   got.left_drive, got.right_drive, got.finished, got.average_error);
        return;
      end
      want = expected_drives.pop_front();
      checked++;
      if (got.left_drive !== want.left_drive || got.right_drive !== want.right_drive ||
          got.finished !== want.finished || got.average_error !== want.average_error) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: drive %0d exp L=%0d R=%0d fin=%0b avg=%0d got L=%0d R=%0d fin=%0b avg=%0d",
                   checked, want.left_drive, want.right_drive, want.finished,
                   want.average_error, got.left_drive, got.right_drive, got.finished,
                   got.average_error);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, channels, block
  // --------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  reg_index_t            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  dds_in_if #(.POSITION_BITS(POSITION_BITS)) in_ch ();
  dds_out_if                                 out_ch ();

  differential_drive_slew_p_step_top #(
    .STALL_TICKS  (STALL_TICKS),
    .POSITION_BITS(POSITION_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  slew_step_tracker tracker = new();

  bit     idle_on = 1'b1;       // random gaps/stalls allowed
  bit     hold_off_req = 1'b0;  // asks the receiver for one long hold-off
  int     requests_sent = 0;
  int     settings_used = 0;
  longint cur_tgt_left = 0;
  longint cur_tgt_right = 0;

  // --------------------------------------------------------------------------
  // Watch both channels and the register port at each edge. Results are
  // checked before a same-edge request is noted; latency keeps them apart.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    drive_cmd_t got;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        got.left_drive    = out_ch.left_drive;
        got.right_drive   = out_ch.right_drive;
        got.finished      = out_ch.finished;
        got.average_error = out_ch.average_error;
        tracker.compare_drive(got);
      end
      if (cfg_write) tracker.note_reg(cfg_index, cfg_data);
      if (in_ch.valid && in_ch.ready)
        tracker.take_positions(in_ch.left_position, in_ch.right_position, in_ch.new_move);
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, one long hold-off on request so the
  // pipeline fills and in_ch.ready drops.
  // --------------------------------------------------------------------------
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
        hold_off_req <= 1'b0;
        out_ch.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers. Every task starts and ends on a rising-edge step.
  // --------------------------------------------------------------------------
  function automatic logic signed [POSITION_BITS-1:0] fit_pos(longint v);
    if (v > POS_MAX) v = POS_MAX;
    if (v < POS_MIN) v = POS_MIN;
    return POSITION_BITS'(v);
  endfunction

  function automatic longint spread(int unsigned half);
    return longint'($urandom_range(0, 2 * half)) - longint'(half);
  endfunction

  function automatic longint any_pos();
    return longint'($urandom_range(0, 24'hFFFFFF)) + POS_MIN;
  endfunction

  // 0, top, or anything between
  function automatic int unsigned pick_level(int unsigned top);
    case ($urandom_range(0, 9))
      0: return 0;
      1: return top;
      default: return $urandom_range(1, top);
    endcase
  endfunction

  function automatic longint pick_target();
    case ($urandom_range(0, 5))
      0: return POS_MAX;
      1: return POS_MIN;
      2: return 0;
      3: return spread(2000);
      4: return spread(200000);
      default: return any_pos();
    endcase
  endfunction

  task automatic send_positions(longint lpos, longint rpos, bit nm);
    in_ch.valid          <= 1'b1;
    in_ch.left_position  <= fit_pos(lpos);
    in_ch.right_position <= fit_pos(rpos);
    in_ch.new_move       <= nm;
    do @(posedge clk); while (!in_ch.ready);
    requests_sent++;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // all owed drive requests back, then a pipeline's worth of quiet
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_drives.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic load_reg(reg_index_t idx, longint data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(data);
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_all(longint tl, longint tr, longint lim, longint gs, longint gt,
                          longint as, longint at, longint se);
    load_reg(REG_TARGET_LEFT, tl);
    load_reg(REG_TARGET_RIGHT, tr);
    load_reg(REG_DRIVE_LIMIT, lim);
    load_reg(REG_GAIN_STRAIGHT, gs);
    load_reg(REG_GAIN_TURNING, gt);
    load_reg(REG_ACCEL_STRAIGHT, as);
    load_reg(REG_ACCEL_TURNING, at);
    load_reg(REG_SETTLE_ERROR, se);
    cur_tgt_left  = tl;
    cur_tgt_right = tr;
    settings_used++;
  endtask

  // positions close in on the targets, with overshoot, then sit within a few
  // ticks so the settle exit fires; a few finished ticks may follow
  task automatic converging_move();
    longint el, er;
    int     span;
    el   = cur_tgt_left - spread(50);
    er   = cur_tgt_right - spread(50);
    span = $urandom_range(4, 30);
    for (int i = 0; i < span; i++) begin
      send_positions(cur_tgt_left - el, cur_tgt_right - er, i == 0);
      if (i < span - 4) begin
        el = el * (longint'($urandom_range(0, 9)) - 2) / 8;
        er = er * (longint'($urandom_range(0, 9)) - 2) / 8;
      end else begin
        el = spread(3);
        er = spread(3);
      end
    end
    repeat ($urandom_range(0, 3)) send_positions(cur_tgt_left - el, cur_tgt_right - er, 1'b0);
  endtask

  // wheels blocked: the average error stays flat, so the stall exit can fire
  task automatic stuck_move();
    longint lp, rp;
    lp = spread(8388607);
    rp = spread(8388607);
    send_positions(lp, rp, 1'b1);
    repeat ($urandom_range(17, 25)) send_positions(lp, rp, 1'b0);
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 8))
      send_positions(any_pos(), any_pos(), $urandom_range(0, 3) == 0);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int phase_end;
    rst                  <= 1'b1;
    in_ch.valid          <= 1'b0;
    in_ch.left_position  <= '0;
    in_ch.right_position <= '0;
    in_ch.new_move       <= 1'b0;
    cfg_write            <= 1'b0;
    cfg_index            <= REG_TARGET_LEFT;
    cfg_data             <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, register defaults: zero error exits on the first tick
    send_positions(0, 0, 1'b1);
    send_positions(0, 0, 1'b0);              // already finished
    send_positions(-1000, -1000, 1'b1);      // straight, cap ramps
    send_positions(-900, -900, 1'b0);
    send_positions(-800, 800, 1'b0);         // turning
    send_positions(0, -300, 1'b0);           // zero vs positive error: turning
    send_positions(POS_MAX, POS_MIN, 1'b1);  // position extremes
    send_positions(POS_MIN, POS_MAX, 1'b0);
    send_positions(3, -2, 1'b0);
    send_positions(1, 1, 1'b0);              // two small averages: settle
    wait_idle();

    // top of every register: average error at its largest
    load_all(POS_MAX, POS_MIN, 127, 4095, 4095, 127, 127, 255);
    send_positions(POS_MIN, POS_MAX, 1'b1);
    send_positions(0, 0, 1'b0);
    wait_idle();

    // bottom of every register: zero cap, no settle exit possible
    load_all(0, 0, 0, 0, 0, 0, 0, 0);
    send_positions(100, -5, 1'b1);
    send_positions(100, -5, 1'b0);
    wait_idle();

    // cap at 127, then the limit is lowered mid-move and clamps it
    load_reg(REG_DRIVE_LIMIT, 127);
    load_reg(REG_GAIN_STRAIGHT, 4095);
    load_reg(REG_ACCEL_STRAIGHT, 127);
    send_positions(-500, -500, 1'b1);
    wait_idle();
    load_reg(REG_DRIVE_LIMIT, 10);
    send_positions(-400, -400, 1'b0);

    // random phases, each with fresh register values; the last has no idling
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      load_all(pick_target(), pick_target(), pick_level(127), pick_level(4095),
               pick_level(4095), pick_level(127), pick_level(127), pick_level(255));
      idle_on <= (p != RANDOM_PHASES - 1);
      if (p == 1) hold_off_req <= 1'b1;
      phase_end = requests_sent + PHASE_ITEMS;
      while (requests_sent < phase_end) begin
        case ($urandom_range(0, 9))
          0, 1:    stuck_move();
          2, 3:    noise_burst();
          default: converging_move();
        endcase
      end
    end

    wait_idle();
    $display("Summary: %0d requests over %0d register settings, %0d drive results checked",
             requests_sent, settings_used, tracker.checked);
    $display("Summary: %0d settle exits, %0d stall exits, one %0d-cycle receiver hold-off",
             tracker.settle_exits, tracker.stall_exits, HOLD_CYCLES);
    if (tracker.mismatches == 0 && tracker.expected_drives.size() == 0) begin
      $display("== PASS ==");
    end else begin
      if (tracker.expected_drives.size() != 0)
        $display("ERROR: %0d drive results never arrived", tracker.expected_drives.size());
      $display("ERROR: %0d mismatches", tracker.mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(RUN_LIMIT);
    $display("ERROR: run did not complete in time");
    $display("== FAIL ==");
    $finish;
  end

endmodule
